// ----- rtl/core/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU packet cache package
// Shared sizes, configuration and status types and the limit helper.
// ----------------------------------------------------------------------------
package lpc_pkg;

    // Store size and the widths that follow from it.
    localparam int CAPACITY = 2048;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths.
    localparam int ITEM_W  = 16;
    localparam int BLOCK_W = 16;
    localparam int TAG_W   = ITEM_W + BLOCK_W;
    localparam int LAT_W   = 16;
    localparam int LIMIT_W = 12;
    localparam int CFG_D_W = 16;
    localparam int CFG_I_W = 3;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_I_W-1:0] {
        REG_RANGE_START   = 3'd0,
        REG_RANGE_END     = 3'd1,
        REG_USE_FLASH     = 3'd2,
        REG_ENTRY_LIMIT   = 3'd3,
        REG_HIT_LATENCY   = 3'd4,
        REG_FLASH_LATENCY = 3'd5,
        REG_DISK_LATENCY  = 3'd6
    } reg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [ITEM_W-1:0]  RST_RANGE_START   = 16'd0;
    localparam logic [ITEM_W-1:0]  RST_RANGE_END     = 16'd65535;
    localparam logic               RST_USE_FLASH     = 1'b0;
    localparam logic [LIMIT_W-1:0] RST_ENTRY_LIMIT   = 12'd2048;
    localparam logic [LAT_W-1:0]   RST_HIT_LATENCY   = 16'd1;
    localparam logic [LAT_W-1:0]   RST_FLASH_LATENCY = 16'd10;
    localparam logic [LAT_W-1:0]   RST_DISK_LATENCY  = 16'd100;

    // Configuration as seen by the lookup sequencer.
    typedef struct packed {
        logic [ITEM_W-1:0]  range_start;
        logic [ITEM_W-1:0]  range_end;
        logic               use_flash;
        logic [LIMIT_W-1:0] entry_limit;
        logic [LAT_W-1:0]   hit_latency;
        logic [LAT_W-1:0]   flash_latency;
        logic [LAT_W-1:0]   disk_latency;
    } cfg_t;

    // Sequencer status towards the top level.
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } stat_t;

    // A limit of zero acts as one, a limit above the store size as the store size.
    function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] lim);
        int unsigned l;
        l = int'(lim);
        if (l < 1)
            l = 1;
        if (l > CAPACITY)
            l = CAPACITY;
        return CNT_W'(l);
    endfunction

endpackage

// ----- rtl/core/lpc_cfg.sv -----
// ----------------------------------------------------------------------------
// LRU packet cache configuration registers
// Write-only register bank; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module lpc_cfg
    import lpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_I_W-1:0] cfg_index,
    input  logic [CFG_D_W-1:0] cfg_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // The bank takes a write in every cycle.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_RANGE_START:   cfg_next.range_start   = cfg_data;
                REG_RANGE_END:     cfg_next.range_end     = cfg_data;
                REG_USE_FLASH:     cfg_next.use_flash     = cfg_data[0];
                REG_ENTRY_LIMIT:   cfg_next.entry_limit   = cfg_data[LIMIT_W-1:0];
                REG_HIT_LATENCY:   cfg_next.hit_latency   = cfg_data;
                REG_FLASH_LATENCY: cfg_next.flash_latency = cfg_data;
                REG_DISK_LATENCY:  cfg_next.disk_latency  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_start   <= RST_RANGE_START;
            cfg_reg.range_end     <= RST_RANGE_END;
            cfg_reg.use_flash     <= RST_USE_FLASH;
            cfg_reg.entry_limit   <= RST_ENTRY_LIMIT;
            cfg_reg.hit_latency   <= RST_HIT_LATENCY;
            cfg_reg.flash_latency <= RST_FLASH_LATENCY;
            cfg_reg.disk_latency  <= RST_DISK_LATENCY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/lpc_tag_ram.sv -----
// ----------------------------------------------------------------------------
// LRU packet cache tag RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpc_tag_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

endmodule

// ----- rtl/core/lpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// LRU packet cache lookup sequencer
// Searches the recency-ordered tag RAM, then shifts it down and writes the
// requested tag to the most recent position.
// ----------------------------------------------------------------------------
module lpc_ctrl
    import lpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               start,
    input  logic [ITEM_W-1:0]  item_number,
    input  logic [BLOCK_W-1:0] block_number,
    output stat_t              stat,
    output logic               done,
    output logic [LAT_W-1:0]   response_time,
    output logic               was_hit
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_WRITE0 = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             hit_reg, hit_next;
    logic             done_reg, done_next;
    logic [LAT_W-1:0] resp_reg, resp_next;
    logic             was_hit_reg, was_hit_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [TAG_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [TAG_W-1:0] ram_rdata;

    logic             in_range;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] keep;
    logic [CNT_W-1:0] top;
    logic             match;
    logic             last;

    // Tags are held in recency order: entry 0 is the most recent.
    lpc_tag_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (TAG_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Range check, limit and the number of tags kept on a miss.
    assign in_range = (item_number >= cfg.range_start) && (item_number <= cfg.range_end);
    assign lim      = eff_limit(cfg.entry_limit);
    assign keep     = (count_reg > lim - CNT_W'(1)) ? lim - CNT_W'(1) : count_reg;
    assign match    = (ram_rdata == tag_reg);
    assign last     = (idx_reg == count_reg - CNT_W'(1));

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        tag_next     = tag_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        done_next    = 1'b0;
        resp_next    = resp_reg;
        was_hit_next = was_hit_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = tag_reg;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        top          = '0;

        case (state_reg)
            S_IDLE:
            begin
                // Out-of-range items are dropped at once.
                if (start && in_range)
                begin
                    tag_next = {item_number, block_number};
                    if (count_reg == '0)
                    begin
                        hit_next   = 1'b0;
                        count_next = CNT_W'(1);
                        state_next = S_WRITE0;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        idx_next   = '0;
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // One tag compared per cycle while the next one is read.
                if (match || last)
                begin
                    if (match)
                    begin
                        hit_next = 1'b1;
                        top      = idx_reg;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        top        = keep;
                        count_next = keep + CNT_W'(1);
                    end
                    if (top == '0)
                    begin
                        state_next = S_WRITE0;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = IDX_W'(top - CNT_W'(1));
                        idx_next   = top;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = IDX_W'(idx_reg + CNT_W'(1));
                    idx_next  = idx_reg + CNT_W'(1);
                end
            end

            S_SHIFT:
            begin
                // Entry idx takes entry idx-1; the read runs one entry ahead.
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IDX_W-1:0];
                ram_wdata = ram_rdata;
                if (idx_reg == CNT_W'(1))
                begin
                    state_next = S_WRITE0;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = IDX_W'(idx_reg - CNT_W'(2));
                    idx_next  = idx_reg - CNT_W'(1);
                end
            end

            S_WRITE0:
            begin
                // The requested tag becomes the most recent and the result is issued.
                ram_we       = 1'b1;
                ram_waddr    = '0;
                ram_wdata    = tag_reg;
                done_next    = 1'b1;
                was_hit_next = hit_reg;
                if (hit_reg)
                    resp_next = cfg.hit_latency;
                else if (cfg.use_flash)
                    resp_next = cfg.flash_latency;
                else
                    resp_next = cfg.disk_latency;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Working and result payload.
    always_ff @(posedge clk)
    begin
        tag_reg     <= tag_next;
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        resp_reg    <= resp_next;
        was_hit_reg <= was_hit_next;
    end

    assign stat.busy     = (state_reg != S_IDLE);
    assign stat.count    = count_reg;
    assign done          = done_reg;
    assign response_time = resp_reg;
    assign was_hit       = was_hit_reg;

endmodule

// ----- rtl/core/lru_packet_cache_latency.sv -----
// ----------------------------------------------------------------------------
// LRU packet cache with latency reporting
// A lookup keeps busy high while it searches, shifts and writes the tag to
// entry 0; a hit at position p shifts p entries, a miss the K tags kept. The
// result strobe comes in the cycle after the last busy cycle. The search reads
// one tag per cycle and the shift moves one entry per cycle through the single
// tag RAM. Out-of-range items are dropped and give no result. The receiver cannot
// stall. Reset empties the cache (count to zero) and loads the default registers.
// ----------------------------------------------------------------------------
module lru_packet_cache_latency
    import lpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [ITEM_W-1:0]  item_number,
    input  logic [BLOCK_W-1:0] block_number,
    output logic               done,
    output logic [LAT_W-1:0]   response_time,
    output logic               was_hit,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_I_W-1:0] cfg_index,
    input  logic [CFG_D_W-1:0] cfg_data
);

    cfg_t  cfg;
    stat_t stat;

    // Configuration bank.
    lpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Lookup and recency update.
    lpc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .start         (start),
        .item_number   (item_number),
        .block_number  (block_number),
        .stat          (stat),
        .done          (done),
        .response_time (response_time),
        .was_hit       (was_hit)
    );

    assign busy = stat.busy;

    // A result only follows a busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without preceding lookup");

    // An accepted item never gives a result in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> !done)
        else $error("result strobe directly after acceptance");

    // The tag count stays within the store.
    assert property (@(posedge clk) disable iff (!rst_n) stat.count <= CNT_W'(CAPACITY))
        else $error("tag count beyond capacity");

    // A hit leaves the tag count unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && was_hit) |-> $stable(stat.count))
        else $error("tag count changed on a hit");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for the LRU packet cache with latency reporting
// Requests are driven through the start/busy handshake and every response is
// checked against an LRU tag list kept in the bench. Directed requests come
// first, then random phases. Each phase uses its own register settings, and
// these are written only while the cache is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import lpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_I_W-1:0] REG_UNUSED = 3'd7;

    // Run limit in ns. It covers every item searching a full store.
    localparam int RUN_LIMIT_NS = 20_000_000;

    typedef struct {
        logic [ITEM_W-1:0]  item;
        logic [BLOCK_W-1:0] blk;
        int                 gap;
        bit                 drain;
    } cache_req_t;

    typedef struct packed {
        logic [LAT_W-1:0] resp_time;
        logic             hit;
    } cache_resp_t;

    typedef struct {
        logic [ITEM_W-1:0]  range_lo;
        logic [ITEM_W-1:0]  range_hi;
        logic               flash;
        logic [LIMIT_W-1:0] limit;
        logic [LAT_W-1:0]   hit_lat;
        logic [LAT_W-1:0]   flash_lat;
        logic [LAT_W-1:0]   disk_lat;
    } cache_cfg_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [ITEM_W-1:0]  item_number = '0;
    logic [BLOCK_W-1:0] block_number = '0;
    logic               done;
    logic [LAT_W-1:0]   response_time;
    logic               was_hit;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_I_W-1:0] cfg_index = '0;
    logic [CFG_D_W-1:0] cfg_data = '0;

    // Settings and tag list of the cache as the bench sees them.
    // The front of the tag list is the most recent tag.
    cache_cfg_t       cache_cfg = '{RST_RANGE_START, RST_RANGE_END, RST_USE_FLASH,
                                    RST_ENTRY_LIMIT, RST_HIT_LATENCY,
                                    RST_FLASH_LATENCY, RST_DISK_LATENCY};
    logic [TAG_W-1:0] lru_tags[$];

    cache_req_t  request_queue[$];
    cache_resp_t expected_responses[$];
    cache_req_t  cur_req;
    int          items_queued = 0;
    int          items_taken = 0;
    int          idle_left = 0;
    int          errors = 0;
    bit          item_taken = 1'b0;
    bit          driving = 1'b0;
    bit          loaded = 1'b0;

    lru_packet_cache_latency DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item_number   (item_number),
        .block_number  (block_number),
        .done          (done),
        .response_time (response_time),
        .was_hit       (was_hit),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with an 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Look one request up in the bench's tag list and update it. Returns 1 when
    // the request is in range and so gives a response.
    function automatic bit cache_lookup(input logic [ITEM_W-1:0] it,
                                        input logic [BLOCK_W-1:0] blk,
                                        output cache_resp_t r);
        logic [TAG_W-1:0] tag;
        int pos;
        int lim;
        int keep;
        tag = {it, blk};
        r = '0;
        if (it < cache_cfg.range_lo || it > cache_cfg.range_hi)
            return 1'b0;
        pos = -1;
        for (int i = 0; i < lru_tags.size(); i++)
        begin
            if (pos < 0 && lru_tags[i] == tag)
                pos = i;
        end
        if (pos >= 0)
        begin
            // A hit moves the tag to the front and evicts nothing.
            lru_tags.delete(pos);
            lru_tags.push_front(tag);
            r.resp_time = cache_cfg.hit_lat;
            r.hit = 1'b1;
            return 1'b1;
        end
        // A zero limit acts as one, and a limit above the store size as the size.
        lim = int'(cache_cfg.limit);
        if (lim < 1)
            lim = 1;
        if (lim > CAPACITY)
            lim = CAPACITY;
        keep = lru_tags.size();
        if (keep > lim - 1)
            keep = lim - 1;
        while (lru_tags.size() > keep)
            void'(lru_tags.pop_back());
        lru_tags.push_front(tag);
        r.resp_time = cache_cfg.flash ? cache_cfg.flash_lat : cache_cfg.disk_lat;
        r.hit = 1'b0;
        return 1'b1;
    endfunction

    // Record each accepted item and what it should return.
    always @(posedge clk)
    begin : accept_requests
        cache_resp_t r;
        if (rst_n && start && !busy)
        begin
            if (cache_lookup(item_number, block_number, r))
                expected_responses.insert(expected_responses.size(), r);
            items_taken++;
            item_taken = 1'b1;
        end
    end

    // Drive the next item after its idle gap and, when the item asks for that,
    // once the cache has drained.
    always @(negedge clk)
    begin : drive_requests
        if (item_taken)
        begin
            driving = 1'b0;
            item_taken = 1'b0;
        end
        if (!driving && !loaded && request_queue.size() > 0)
        begin
            cur_req = request_queue[0];
            request_queue.delete(0);
            loaded = 1'b1;
            idle_left = cur_req.gap;
        end
        if (!driving && loaded)
        begin
            if (idle_left > 0)
                idle_left--;
            else if (!cur_req.drain || expected_responses.size() == 0)
            begin
                driving = 1'b1;
                loaded = 1'b0;
            end
        end
        start <= driving;
        if (driving)
        begin
            item_number <= cur_req.item;
            block_number <= cur_req.blk;
        end
    end

    // Compare each response with the oldest expected one.
    always @(posedge clk)
    begin : check_responses
        cache_resp_t want;
        if (rst_n && done)
        begin
            if (expected_responses.size() == 0)
            begin
                $display("%0t ns: response with none expected: expected none, actual time %0d hit %0b",
                         $time, response_time, was_hit);
                errors++;
            end
            else
            begin
                want = expected_responses[0];
                expected_responses.delete(0);
                if (response_time !== want.resp_time)
                begin
                    $display("%0t ns: response_time mismatch: expected %0d, actual %0d",
                             $time, want.resp_time, response_time);
                    errors++;
                end
                if (was_hit !== want.hit)
                begin
                    $display("%0t ns: was_hit mismatch: expected %0b, actual %0b",
                             $time, want.hit, was_hit);
                    errors++;
                end
            end
        end
    end

    // Queue one request for the driver.
    task automatic send_req(input logic [ITEM_W-1:0] it, input logic [BLOCK_W-1:0] blk,
                            input int gap, input bit drain);
        cache_req_t q;
        q.item = it;
        q.blk = blk;
        q.gap = gap;
        q.drain = drain;
        request_queue.insert(request_queue.size(), q);
        items_queued++;
    endtask

    // Write one register and mirror it once the write is accepted.
    task automatic write_reg(input logic [CFG_I_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_RANGE_START:   cache_cfg.range_lo = val[ITEM_W-1:0];
            REG_RANGE_END:     cache_cfg.range_hi = val[ITEM_W-1:0];
            REG_USE_FLASH:     cache_cfg.flash = val[0];
            REG_ENTRY_LIMIT:   cache_cfg.limit = val[LIMIT_W-1:0];
            REG_HIT_LATENCY:   cache_cfg.hit_lat = val[LAT_W-1:0];
            REG_FLASH_LATENCY: cache_cfg.flash_lat = val[LAT_W-1:0];
            REG_DISK_LATENCY:  cache_cfg.disk_lat = val[LAT_W-1:0];
            default: ;
        endcase
    endtask

    // Close a batch of register writes.
    task automatic end_writes();
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every item is taken and answered, and the cache is idle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_taken != items_queued || expected_responses.size() != 0);
        while (busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic int pick_gap(input int idle_pct);
        if ($urandom_range(99) < idle_pct)
            return $urandom_range(1, 13);
        return 0;
    endfunction

    function automatic logic [LAT_W-1:0] pick_latency();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return LAT_W'($urandom);
        endcase
    endfunction

    // One random phase: fresh settings, then requests that mostly revisit a
    // small set of tags so that hits, reordering and eviction all occur.
    task automatic run_random_phase(input int n, input int idle_pct);
        logic [TAG_W-1:0] pool[$];
        logic [TAG_W-1:0] tag;
        int lo;
        int hi;
        int lim;
        int pick;
        if ($urandom_range(9) < 3)
        begin
            lo = 0;
            hi = 65535;
        end
        else
        begin
            lo = $urandom_range(0, 65535);
            hi = lo + $urandom_range(0, 4096);
            if (hi > 65535)
                hi = 65535;
        end
        case ($urandom_range(5))
            0: lim = 0;
            1: lim = 1;
            2: lim = 2;
            3: lim = $urandom_range(3, 12);
            4: lim = CAPACITY;
            default: lim = 4095;
        endcase
        write_reg(REG_RANGE_START, CFG_D_W'(lo));
        write_reg(REG_RANGE_END, CFG_D_W'(hi));
        write_reg(REG_USE_FLASH, CFG_D_W'($urandom));
        write_reg(REG_ENTRY_LIMIT, {4'($urandom_range(15)), 12'(lim)});
        write_reg(REG_HIT_LATENCY, pick_latency());
        write_reg(REG_FLASH_LATENCY, pick_latency());
        write_reg(REG_DISK_LATENCY, pick_latency());
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, CFG_D_W'($urandom));
        end_writes();

        repeat ($urandom_range(3, 10))
            pool.insert(pool.size(), {16'($urandom_range(lo, hi)), 16'($urandom)});
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                tag = pool[$urandom_range(pool.size() - 1)];
            else if (pick < 85)
                tag = {16'($urandom_range(lo, hi)), 16'($urandom)};
            else
                tag = TAG_W'($urandom);
            send_req(tag[TAG_W-1:BLOCK_W], tag[BLOCK_W-1:0], pick_gap(idle_pct),
                     idle_pct > 0 && $urandom_range(29) == 0);
        end
        wait_drained();
    endtask

    // Stimulus: reset, directed phases, random phases, then the verdict.
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: field extremes, a hit near the front and one deep down.
        send_req(16'h0000, 16'h0000, 0, 1'b0);
        send_req(16'hFFFF, 16'hFFFF, 0, 1'b0);
        send_req(16'h0000, 16'h0000, 3, 1'b0);
        send_req(16'h0000, 16'hFFFF, 0, 1'b0);
        send_req(16'hFFFF, 16'h0000, 13, 1'b0);
        send_req(16'hAAAA, 16'h5555, 0, 1'b0);
        send_req(16'h5555, 16'hAAAA, 0, 1'b1);
        send_req(16'hFFFF, 16'hFFFF, 0, 1'b0);
        wait_drained();

        // Limit lowered below the count: hits evict nothing, the next miss trims.
        write_reg(REG_USE_FLASH, 16'hFFFF);
        write_reg(REG_ENTRY_LIMIT, 16'd3);
        write_reg(REG_HIT_LATENCY, 16'hFFFF);
        write_reg(REG_FLASH_LATENCY, 16'h0000);
        write_reg(REG_DISK_LATENCY, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        end_writes();
        send_req(16'h0000, 16'hFFFF, 0, 1'b0);
        send_req(16'hFFFF, 16'h0000, 0, 1'b0);
        send_req(16'h1234, 16'h5678, 2, 1'b0);
        send_req(16'h0000, 16'h0000, 0, 1'b0);
        send_req(16'h1234, 16'h5678, 0, 1'b0);
        send_req(16'h0000, 16'hFFFF, 0, 1'b0);
        wait_drained();

        // Range edges, and a zero limit that acts as a limit of one.
        write_reg(REG_RANGE_START, 16'h0100);
        write_reg(REG_RANGE_END, 16'h01FF);
        write_reg(REG_ENTRY_LIMIT, 16'h0000);
        write_reg(REG_USE_FLASH, 16'h0000);
        write_reg(REG_DISK_LATENCY, 16'h8000);
        end_writes();
        send_req(16'h00FF, 16'h0001, 0, 1'b0);
        send_req(16'h0200, 16'h0001, 0, 1'b0);
        send_req(16'h0100, 16'h0000, 0, 1'b0);
        send_req(16'h01FF, 16'hFFFF, 5, 1'b0);
        send_req(16'h01FF, 16'hFFFF, 0, 1'b0);
        send_req(16'h0100, 16'h0000, 0, 1'b0);
        wait_drained();

        // Empty range gives nothing; the limit field at its top exceeds the store.
        write_reg(REG_RANGE_START, 16'd5);
        write_reg(REG_RANGE_END, 16'd4);
        write_reg(REG_ENTRY_LIMIT, 16'hFFFF);
        end_writes();
        send_req(16'h0004, 16'h0000, 0, 1'b0);
        send_req(16'h0005, 16'h0000, 0, 1'b0);
        send_req(16'h0000, 16'h0000, 0, 1'b0);
        send_req(16'hFFFF, 16'hFFFF, 0, 1'b0);
        wait_drained();

        // Random phases; the last one runs with no idling at all.
        run_random_phase(23, 30);
        run_random_phase(23, 0);
        run_random_phase(23, 60);
        run_random_phase(23, 25);
        run_random_phase(23, 0);

        repeat (2 * CAPACITY + 16) @(negedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
